[design/pts_pkg.sv]
// Package for the priority task scheduler.
// Holds the operation codes, the sequencer states and the ready-mask search.
// No dependencies.
package pts_pkg;

  localparam int unsigned MaskW  = 8;
  localparam int unsigned PrioW  = 4;
  localparam int unsigned TicksW = 32;

  // Running thread value when nothing has been scheduled yet
  localparam logic [PrioW-1:0] NoThread = 4'd15;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_DELAY    = 2'd1,
    OP_START    = 2'd2,
    OP_SCHEDULE = 2'd3
  } opcode_e;

  typedef enum logic {
    S_IDLE,
    S_TICK
  } state_e;

  // Highest set bit of the mask as a priority (bit p-1 is priority p), 0 if empty
  function automatic logic [PrioW-1:0] highest_ready(input logic [MaskW-1:0] mask);
    logic [PrioW-1:0] prio;
    prio = '0;
    for (int i = 0; i < MaskW; i++) begin
      if (mask[i]) begin
        prio = PrioW'(i + 1);
      end
    end
    return prio;
  endfunction

endpackage

[design/priority_task_scheduler.sv]
// Top level of the priority task scheduler.
// Depends on pts_pkg for opcodes, sequencer states and the ready-mask search.

// Bitmap scheduler: a thread is named by its priority 1..THREAD_COUNT, 0 is
// idle. Each input beat carries one operation, with the opcode in
// s_axis_tuser, and yields exactly one result beat. Start, delay and schedule
// are resolved in the accept cycle and their result is valid on the next
// cycle. A tick walks the per-thread timeout counters one thread per cycle
// through a single shared decrementer, and its result is valid once the
// walk has passed the last thread. The input is ready again once the result
// beat has been taken. No clearing pass is needed after reset.
module priority_task_scheduler #(
  parameter int unsigned THREAD_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] priority_req, [35:4] delay_ticks, [39:36] zero
  input  logic [39:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] next_thread, [4] switch_request, [12:5] ready_bits,
  // [20:13] delayed_bits, [21] start_error, [23:22] zero
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned MaskW  = pts_pkg::MaskW;
  localparam int unsigned PrioW  = pts_pkg::PrioW;
  localparam int unsigned TicksW = pts_pkg::TicksW;
  localparam int unsigned IdxW   = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam logic [PrioW-1:0] ThreadCnt = PrioW'(THREAD_COUNT);
  localparam logic [IdxW-1:0]  LastIdx   = IdxW'(THREAD_COUNT - 1);

  pts_pkg::state_e state_q, state_d;

  logic [MaskW-1:0]  ready_q, ready_d;
  logic [MaskW-1:0]  delay_q, delay_d;
  logic [PrioW-1:0]  cur_q, cur_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [TicksW-1:0] tmo_q [THREAD_COUNT];

  logic              out_valid_q, out_valid_d;
  logic [PrioW-1:0]  out_next_q, out_next_d;
  logic              out_switch_q, out_switch_d;
  logic              out_err_q, out_err_d;
  logic [MaskW-1:0]  out_ready_q, out_ready_d;
  logic [MaskW-1:0]  out_delay_q, out_delay_d;

  pts_pkg::opcode_e  op;
  logic [PrioW-1:0]  prio_req;
  logic [TicksW-1:0] ticks;
  logic              in_beat;
  logic              out_beat;

  logic              cur_real;
  logic [IdxW-1:0]   cur_idx;
  logic [MaskW-1:0]  cur_bit;
  logic [IdxW-1:0]   req_idx;
  logic [MaskW-1:0]  req_bit;
  logic [MaskW-1:0]  walk_bit;
  logic              walk_hit;
  logic [TicksW-1:0] walk_cnt;
  logic              walk_expire;
  logic [TicksW-1:0] walk_dec;
  logic              tmo_we;
  logic [IdxW-1:0]   tmo_waddr;
  logic [TicksW-1:0] tmo_wdata;
  logic [PrioW-1:0]  sched_next;
  logic [MaskW-1:0]  sched_mask;

  assign op       = pts_pkg::opcode_e'(s_axis_tuser);
  assign prio_req = s_axis_tdata[3:0];
  assign ticks    = s_axis_tdata[35:4];

  assign s_axis_tready = (state_q == pts_pkg::S_IDLE) && !out_valid_q;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = out_valid_q && m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_err_q, out_delay_q, out_ready_q, out_switch_q, out_next_q};

  // Thread selects; priority p lives at index p-1
  assign cur_real = (cur_q != '0) && (cur_q <= ThreadCnt);
  assign cur_idx  = IdxW'(cur_q - PrioW'(1));
  assign cur_bit  = MaskW'(1) << cur_idx;
  assign req_idx  = IdxW'(prio_req - PrioW'(1));
  assign req_bit  = MaskW'(1) << req_idx;

  // Shared saturating decrementer for the tick walk
  assign walk_bit    = MaskW'(1) << idx_q;
  assign walk_hit    = (delay_q & walk_bit) != '0;
  assign walk_cnt    = tmo_q[idx_q];
  assign walk_expire = walk_cnt <= TicksW'(1);
  assign walk_dec    = walk_expire ? '0 : walk_cnt - TicksW'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      pts_pkg::S_IDLE: begin
        if (in_beat && op == pts_pkg::OP_TICK) begin
          state_d = pts_pkg::S_TICK;
          idx_d   = '0;
        end
      end
      pts_pkg::S_TICK: begin
        idx_d = idx_q + IdxW'(1);
        if (idx_q == LastIdx) begin
          state_d = pts_pkg::S_IDLE;
        end
      end
      default: state_d = pts_pkg::S_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    ready_d      = ready_q;
    delay_d      = delay_q;
    cur_d        = cur_q;
    out_valid_d  = out_valid_q && !out_beat;
    out_next_d   = out_next_q;
    out_switch_d = out_switch_q;
    out_err_d    = out_err_q;
    out_ready_d  = out_ready_q;
    out_delay_d  = out_delay_q;
    tmo_we       = 1'b0;
    tmo_waddr    = idx_q;
    tmo_wdata    = walk_dec;
    sched_mask   = ready_q;
    sched_next   = pts_pkg::highest_ready(sched_mask);

    unique case (state_q)
      pts_pkg::S_IDLE: begin
        if (in_beat) begin
          out_next_d   = '0;
          out_switch_d = 1'b0;
          out_err_d    = 1'b0;
          case (op)
            pts_pkg::OP_DELAY: begin
              if (cur_real) begin
                tmo_we     = 1'b1;
                tmo_waddr  = cur_idx;
                tmo_wdata  = ticks;
                sched_mask = ready_q & ~cur_bit;
                delay_d    = delay_q | cur_bit;
              end
              sched_next   = pts_pkg::highest_ready(sched_mask);
              ready_d      = sched_mask;
              cur_d        = sched_next;
              out_next_d   = sched_next;
              out_switch_d = sched_next != cur_q;
            end
            pts_pkg::OP_START: begin
              if (prio_req > ThreadCnt) begin
                out_err_d = 1'b1;
              end else if (prio_req != '0) begin
                ready_d = ready_q | req_bit;
                delay_d = delay_q & ~req_bit;
              end
            end
            pts_pkg::OP_SCHEDULE: begin
              cur_d        = sched_next;
              out_next_d   = sched_next;
              out_switch_d = sched_next != cur_q;
            end
            default: ;
          endcase
          // tick results are loaded when the walk ends
          if (op != pts_pkg::OP_TICK) begin
            out_valid_d = 1'b1;
            out_ready_d = ready_d;
            out_delay_d = delay_d;
          end
        end
      end
      pts_pkg::S_TICK: begin
        if (walk_hit) begin
          tmo_we = 1'b1;
          if (walk_expire) begin
            ready_d = ready_q | walk_bit;
            delay_d = delay_q & ~walk_bit;
          end
        end
        if (idx_q == LastIdx) begin
          out_valid_d = 1'b1;
          out_ready_d = ready_d;
          out_delay_d = delay_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pts_pkg::S_IDLE;
      idx_q       <= '0;
      ready_q     <= '0;
      delay_q     <= '0;
      cur_q       <= pts_pkg::NoThread;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      ready_q     <= ready_d;
      delay_q     <= delay_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_next_q   <= out_next_d;
    out_switch_q <= out_switch_d;
    out_err_q    <= out_err_d;
    out_ready_q  <= out_ready_d;
    out_delay_q  <= out_delay_d;
  end

  // Timeout counters: one write port, shared by delay and the tick walk
  always_ff @(posedge clk_i) begin
    if (tmo_we) begin
      tmo_q[tmo_waddr] <= tmo_wdata;
    end
  end

endmodule

[test/priority_task_scheduler_tb.sv]
`timescale 1ns / 1ps
// Testbench for priority_task_scheduler: random and directed scheduler operations,
// checked beat by beat against an in-bench prediction. Depends on pts_pkg.
module priority_task_scheduler_tb;

  localparam int unsigned ThreadCount = 8;
  localparam int unsigned PhaseItems  = 360;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned MaskW       = pts_pkg::MaskW;
  localparam int unsigned PrioW       = pts_pkg::PrioW;
  localparam int unsigned TicksW      = pts_pkg::TicksW;

  typedef struct packed {
    logic [PrioW-1:0] next_thread;
    logic             switch_req;
    logic [MaskW-1:0] ready_bits;
    logic [MaskW-1:0] delayed_bits;
    logic             start_err;
  } sched_result_t;

  // Tracks scheduler state and holds the results still owed by the DUT
  class sched_tracker;
    logic [MaskW-1:0]  ready_mask;
    logic [MaskW-1:0]  delay_mask;
    logic [TicksW-1:0] timeout_cnt [ThreadCount];
    logic [PrioW-1:0]  running;
    sched_result_t     pending_results[$];
    int unsigned       mismatches;

    function new();
      ready_mask  = '0;
      delay_mask  = '0;
      running     = pts_pkg::NoThread;
      mismatches  = 0;
      foreach (timeout_cnt[i]) timeout_cnt[i] = '0;
    endfunction

    function automatic void pick_next(ref sched_result_t res);
      logic [PrioW-1:0] best;
      best = '0;
      for (int p = 1; p <= ThreadCount; p++) begin
        if (ready_mask[p-1]) begin
          best = PrioW'(p);
        end
      end
      res.next_thread = best;
      if (best != running) begin
        res.switch_req = 1'b1;
        running        = best;
      end
    endfunction

    // Predict the result beat for one accepted operation
    function automatic void apply_op(pts_pkg::opcode_e op, logic [PrioW-1:0] prio,
                                     logic [TicksW-1:0] ticks);
      sched_result_t res;
      res = '0;
      case (op)
        pts_pkg::OP_TICK: begin
          for (int p = 1; p <= ThreadCount; p++) begin
            if (delay_mask[p-1]) begin
              if (timeout_cnt[p-1] <= 1) begin
                timeout_cnt[p-1] = '0;
                ready_mask[p-1]  = 1'b1;
                delay_mask[p-1]  = 1'b0;
              end else begin
                timeout_cnt[p-1] = timeout_cnt[p-1] - 1;
              end
            end
          end
        end
        pts_pkg::OP_DELAY: begin
          // idle, none or out-of-range running thread blocks nothing
          if (running >= 1 && running <= ThreadCount) begin
            timeout_cnt[running-1] = ticks;
            ready_mask[running-1]  = 1'b0;
            delay_mask[running-1]  = 1'b1;
          end
          pick_next(res);
        end
        pts_pkg::OP_START: begin
          if (prio > ThreadCount) begin
            res.start_err = 1'b1;
          end else if (prio >= 1) begin
            ready_mask[prio-1] = 1'b1;
            delay_mask[prio-1] = 1'b0;
          end
        end
        default: begin
          pick_next(res);
        end
      endcase
      res.ready_bits   = ready_mask;
      res.delayed_bits = delay_mask;
      pending_results.push_back(res);
    endfunction

    function automatic void check_beat(logic [23:0] data);
      sched_result_t got;
      sched_result_t exp;
      got.next_thread  = data[3:0];
      got.switch_req   = data[4];
      got.ready_bits   = data[12:5];
      got.delayed_bits = data[20:13];
      got.start_err    = data[21];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: unexpected result beat %h", $realtime, data);
        end
        return;
      end
      exp = pending_results.pop_front();
      if (got.next_thread !== exp.next_thread || got.switch_req !== exp.switch_req ||
          got.ready_bits !== exp.ready_bits || got.delayed_bits !== exp.delayed_bits ||
          got.start_err !== exp.start_err || data[23:22] !== 2'b00) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: mismatch next %0d/%0d sw %b/%b ready %h/%h delayed %h/%h err %b/%b",
                   $realtime, exp.next_thread, got.next_thread, exp.switch_req,
                   got.switch_req, exp.ready_bits, got.ready_bits, exp.delayed_bits,
                   got.delayed_bits, exp.start_err, got.start_err);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  sched_tracker tracker = new();

  priority_task_scheduler #(
    .THREAD_COUNT(ThreadCount)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: backpressure set on the falling edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_beat(m_axis_tdata);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_op(pts_pkg::opcode_e op, logic [PrioW-1:0] prio,
                         logic [TicksW-1:0] ticks);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {4'b0000, ticks, prio};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.apply_op(op, prio, ticks);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_op();
    pts_pkg::opcode_e  op;
    logic [PrioW-1:0]  prio;
    logic [TicksW-1:0] ticks;
    int unsigned       sel;
    sel = $urandom_range(99);
    if (sel < 35) op = pts_pkg::OP_TICK;
    else if (sel < 50) op = pts_pkg::OP_DELAY;
    else if (sel < 75) op = pts_pkg::OP_START;
    else op = pts_pkg::OP_SCHEDULE;
    sel = $urandom_range(99);
    if (sel < 80) prio = PrioW'($urandom_range(ThreadCount, 1));
    else if (sel < 90) prio = '0;
    else prio = PrioW'($urandom_range(15, ThreadCount + 1));
    sel = $urandom_range(99);
    if (sel < 70) ticks = TicksW'($urandom_range(4));
    else if (sel < 90) ticks = TicksW'($urandom_range(40, 5));
    else ticks = $urandom();
    send_op(op, prio, ticks);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = pts_pkg::OP_TICK;
    rst_ni        = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset schedule, idle delay, start edge cases, zero and max delays
    send_op(pts_pkg::OP_SCHEDULE, 4'd0, '0);
    send_op(pts_pkg::OP_DELAY, 4'd15, 32'd3);
    send_op(pts_pkg::OP_START, 4'd0, '0);
    send_op(pts_pkg::OP_START, 4'd9, '0);
    send_op(pts_pkg::OP_START, 4'd15, 32'hFFFF_FFFF);
    send_op(pts_pkg::OP_START, 4'd1, '0);
    send_op(pts_pkg::OP_START, 4'd8, '0);
    send_op(pts_pkg::OP_SCHEDULE, 4'd0, '0);
    send_op(pts_pkg::OP_SCHEDULE, 4'd0, '0);
    send_op(pts_pkg::OP_DELAY, 4'd0, 32'd0);
    send_op(pts_pkg::OP_TICK, 4'd0, '0);
    send_op(pts_pkg::OP_SCHEDULE, 4'd0, '0);
    send_op(pts_pkg::OP_DELAY, 4'd0, 32'hFFFF_FFFF);
    send_op(pts_pkg::OP_DELAY, 4'd0, 32'd1);
    send_op(pts_pkg::OP_TICK, 4'd0, '0);
    send_op(pts_pkg::OP_START, 4'd8, '0);
    send_op(pts_pkg::OP_SCHEDULE, 4'd0, '0);
    send_op(pts_pkg::OP_DELAY, 4'd0, 32'd2);
    send_op(pts_pkg::OP_TICK, 4'd15, 32'hFFFF_FFFF);
    send_op(pts_pkg::OP_TICK, 4'd0, '0);
    send_op(pts_pkg::OP_START, 4'd5, '0);
    send_op(pts_pkg::OP_SCHEDULE, 4'd0, '0);
    drain_results();

    // Random phases; sender waits for all results between phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        send_random_op();
      end
      drain_results();
    end

    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/pts_pkg.sv
design/priority_task_scheduler.sv
test/priority_task_scheduler_tb.sv
